FILE: hdl/encoder_balanced_straight_drive_defines.svh
// ----------------------------------------------------------------------------
// encoder balanced straight drive - assertion macros
// shared concurrent check forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ENCODER_BALANCED_STRAIGHT_DRIVE_DEFINES_SVH
`define ENCODER_BALANCED_STRAIGHT_DRIVE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define EBSD_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ebsd check failed");

// antecedent in one cycle implies consequent in the next
`define EBSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ebsd check failed");

`endif

FILE: hdl/ebsd_pkg.sv
// ----------------------------------------------------------------------------
// ebsd_pkg
// shared widths, register indexes and control structs of the straight drive
// ----------------------------------------------------------------------------
package ebsd_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int DUTY_BITS     = 16;
  localparam int TARGET_BITS   = 23;
  localparam int CF_BITS       = 16;
  localparam int CF_FRAC       = 12;
  localparam int RATIO_FRAC    = 16;
  localparam int RATIO_BITS    = 24;
  localparam int DIVIDEND_BITS = COUNT_BITS + RATIO_FRAC;
  localparam int DIV_STEPS     = DIVIDEND_BITS;
  localparam int CNT_BITS      = $clog2(DIV_STEPS);
  localparam int SCALED_BITS   = DUTY_BITS + RATIO_BITS - RATIO_FRAC;
  localparam int GAIN_PROD     = SCALED_BITS + CF_BITS;

  localparam int IN_DATA_BITS  = 2 * COUNT_BITS;
  localparam int OUT_FIELDS    = 4 + 2 * DUTY_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELDS + 7) / 8) * 8;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = TARGET_BITS;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FORWARD = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SLOW    = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CORR    = 2'd3;

  // item kinds
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic [TARGET_BITS-1:0] target_counts;
    logic                   forward;
    logic [DUTY_BITS-1:0]   slow_duty;
    logic [CF_BITS-1:0]     left_trim;
  } ebsd_cfg_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic div_step;
    logic ratio;
    logic mul1;
    logic mul2;
    logic commit;
  } ebsd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } ebsd_sts_t;

endpackage

FILE: hdl/ebsd_regs.sv
// ----------------------------------------------------------------------------
// ebsd_regs
// configuration register file of the straight drive
// ----------------------------------------------------------------------------
module ebsd_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ebsd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [ebsd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output ebsd_pkg::ebsd_cfg_t              cfg
);
  import ebsd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_counts <= '0;
      cfg.forward       <= 1'b1;
      cfg.slow_duty     <= DUTY_BITS'(19661);
      cfg.left_trim     <= CF_BITS'(4096);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_TARGET:  cfg.target_counts <= cfg_data;
        REG_FORWARD: cfg.forward       <= cfg_data[0];
        REG_SLOW:    cfg.slow_duty     <= cfg_data[DUTY_BITS-1:0];
        REG_CORR:    cfg.left_trim     <= cfg_data[CF_BITS-1:0];
        default:     ;
      endcase
    end
  end

endmodule

FILE: hdl/ebsd_dpath.sv
// ----------------------------------------------------------------------------
// ebsd_dpath
// drive datapath: distance test, ratio divider, duty scaling, result register
// ----------------------------------------------------------------------------
module ebsd_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  ebsd_pkg::ebsd_cmd_t                 cmd,
  output ebsd_pkg::ebsd_sts_t                 sts,
  input  ebsd_pkg::ebsd_cfg_t                 cfg,
  input  logic                                s_tuser,
  input  logic [ebsd_pkg::IN_DATA_BITS-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ebsd_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
  import ebsd_pkg::*;

  // latched item
  logic                         in_mode;
  logic signed [COUNT_BITS-1:0] in_l;
  logic signed [COUNT_BITS-1:0] in_r;

  // drive state
  logic                 moving;
  logic [DUTY_BITS-1:0] left_duty;
  logic [DUTY_BITS-1:0] right_duty;
  logic                 drive_dir;

  // classification
  logic cls_start, cls_reached, cls_left_lag, cls_right_lag;
  logic cls_ratio_pos, cls_den_zero;

  // divider
  logic [DIVIDEND_BITS-1:0] div_q;
  logic [COUNT_BITS-1:0]    div_rem;
  logic [COUNT_BITS-1:0]    div_den;

  logic [RATIO_BITS-1:0]  ratio;
  logic [SCALED_BITS-1:0] scaled;
  logic [DUTY_BITS-1:0]   gain;
  logic                   out_valid;

  // classify terms
  logic signed [COUNT_BITS:0]   sum;
  logic [COUNT_BITS:0]          sum_mag;
  logic                         reached;
  logic                         lt, gt, left_lag, right_lag;
  logic signed [COUNT_BITS-1:0] num;
  logic signed [COUNT_BITS:0]   den;
  logic                         num_neg, den_neg, num_zero, den_zero;
  logic [COUNT_BITS-1:0]        num_mag;
  logic [COUNT_BITS:0]          den_abs;

  always_comb begin
    sum      = COUNT_BITS'(0) + {in_l[COUNT_BITS-1], in_l} + {in_r[COUNT_BITS-1], in_r};
    sum_mag  = sum[COUNT_BITS] ? (COUNT_BITS+1)'(-sum) : COUNT_BITS'(0) + sum;
    reached  = sum_mag >= {1'b0, cfg.target_counts, 1'b0};
    lt       = in_l < in_r;
    gt       = in_r < in_l;
    left_lag  = drive_dir ? lt : gt;
    right_lag = drive_dir ? gt : lt;
    num      = left_lag ? in_r : in_l;
    den      = (left_lag ? {in_l[COUNT_BITS-1], in_l} : {in_r[COUNT_BITS-1], in_r})
               + (COUNT_BITS+1)'(1);
    num_neg  = num[COUNT_BITS-1];
    den_neg  = den[COUNT_BITS];
    num_zero = (num == '0);
    den_zero = (den == '0);
    num_mag  = num_neg ? COUNT_BITS'(-num) : COUNT_BITS'(num);
    den_abs  = den_neg ? (COUNT_BITS+1)'(-den) : (COUNT_BITS+1)'(den);
  end

  assign sts.need_div = (in_mode == MODE_SAMPLE) && moving && !reached
                        && (left_lag || right_lag);
  assign sts.out_free = !out_valid || m_tready;

  // restoring divide step
  logic [COUNT_BITS+1:0] trial;
  assign trial = {1'b0, div_rem, div_q[DIVIDEND_BITS-1]} - {2'b00, div_den};

  // ratio saturation
  logic                  q_big;
  logic [RATIO_BITS-1:0] ratio_next;
  assign q_big = (|div_q[DIVIDEND_BITS-1:RATIO_BITS]) || (&div_q[RATIO_BITS-1:0]);
  always_comb begin
    if (!cls_ratio_pos) ratio_next = '0;
    else if (cls_den_zero || q_big) ratio_next = '1;
    else ratio_next = div_q[RATIO_BITS-1:0];
  end

  // multipliers, one per stage
  logic [DUTY_BITS+RATIO_BITS-1:0] prod1;
  logic [SCALED_BITS-1:0]          gain_in;
  logic [GAIN_PROD-1:0]            prod2;
  logic [GAIN_PROD-CF_FRAC-1:0]    gain_wide;
  assign prod1     = cfg.slow_duty * ratio;
  assign gain_in   = cls_left_lag ? scaled : SCALED_BITS'(cfg.slow_duty);
  assign prod2     = gain_in * cfg.left_trim;
  assign gain_wide = prod2[GAIN_PROD-1:CF_FRAC];

  logic [DUTY_BITS-1:0] scaled_sat;
  assign scaled_sat = (|scaled[SCALED_BITS-1:DUTY_BITS]) ? '1 : scaled[DUTY_BITS-1:0];

  // commit values
  logic                 moving_next, dir_next, en_next, done_next;
  logic [DUTY_BITS-1:0] left_next, right_next;
  always_comb begin
    moving_next = moving;
    dir_next    = drive_dir;
    left_next   = left_duty;
    right_next  = right_duty;
    en_next     = 1'b0;
    done_next   = 1'b0;
    if (cls_start) begin
      dir_next    = cfg.forward;
      left_next   = cfg.slow_duty;
      right_next  = cfg.slow_duty;
      moving_next = 1'b1;
    end else if (moving) begin
      if (cls_reached) begin
        moving_next = 1'b0;
        done_next   = 1'b1;
      end else begin
        en_next = 1'b1;
        if (cls_left_lag) begin
          left_next  = gain;
          right_next = cfg.slow_duty;
        end else if (cls_right_lag) begin
          right_next = scaled_sat;
          left_next  = gain;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_mode <= s_tuser;
      in_l    <= s_tdata[COUNT_BITS-1:0];
      in_r    <= s_tdata[2*COUNT_BITS-1:COUNT_BITS];
    end
    if (cmd.classify) begin
      cls_start     <= (in_mode == MODE_START);
      cls_reached   <= reached;
      cls_left_lag  <= left_lag;
      cls_right_lag <= right_lag;
      cls_den_zero  <= den_zero;
      cls_ratio_pos <= !num_zero && (den_zero ? !num_neg : (num_neg == den_neg));
      div_q         <= {num_mag, RATIO_FRAC'(0)};
      div_rem       <= '0;
      div_den       <= den_abs[COUNT_BITS-1:0];
    end
    if (cmd.div_step) begin
      if (!trial[COUNT_BITS+1]) begin
        div_rem <= trial[COUNT_BITS-1:0];
        div_q   <= {div_q[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        div_rem <= {div_rem[COUNT_BITS-2:0], div_q[DIVIDEND_BITS-1]};
        div_q   <= {div_q[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
    if (cmd.ratio) ratio <= ratio_next;
    if (cmd.mul1) scaled <= prod1[DUTY_BITS+RATIO_BITS-1:RATIO_FRAC];
    if (cmd.mul2) begin
      gain <= (|gain_wide[GAIN_PROD-CF_FRAC-1:DUTY_BITS]) ? '1 : gain_wide[DUTY_BITS-1:0];
    end
    if (cmd.commit) begin
      m_tdata <= {(OUT_DATA_BITS-OUT_FIELDS)'(0), done_next, dir_next, dir_next,
                  ~right_next, ~left_next, en_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moving     <= 1'b0;
      left_duty  <= '0;
      right_duty <= '0;
      drive_dir  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        moving     <= moving_next;
        left_duty  <= left_next;
        right_duty <= right_next;
        drive_dir  <= dir_next;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

endmodule

FILE: hdl/ebsd_ctrl.sv
// ----------------------------------------------------------------------------
// ebsd_ctrl
// sequencer: accept, classify, divide, scale, commit
// ----------------------------------------------------------------------------
`include "encoder_balanced_straight_drive_defines.svh"

module ebsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ebsd_pkg::ebsd_sts_t sts,
  output ebsd_pkg::ebsd_cmd_t cmd
);
  import ebsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLASSIFY, S_DIV, S_RATIO, S_MUL1, S_MUL2, S_COMMIT
  } state_t;

  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_STEPS - 1);

  state_t              state;
  logic [CNT_BITS-1:0] cnt;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = s_tvalid && (state == S_IDLE);
    cmd.classify = (state == S_CLASSIFY);
    cmd.div_step = (state == S_DIV);
    cmd.ratio    = (state == S_RATIO);
    cmd.mul1     = (state == S_MUL1);
    cmd.mul2     = (state == S_MUL2);
    cmd.commit   = (state == S_COMMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_CLASSIFY;
        end
        S_CLASSIFY: begin
          cnt   <= '0;
          state <= sts.need_div ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) state <= S_RATIO;
        end
        S_RATIO:  state <= S_MUL1;
        S_MUL1:   state <= S_MUL2;
        S_MUL2:   state <= S_COMMIT;
        S_COMMIT: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  `EBSD_ASSERT_HOLDS(a_commit_slot_free, !cmd.commit || sts.out_free)
  `EBSD_ASSERT_NEXT(a_accept_to_classify, s_tvalid && s_tready, state == S_CLASSIFY)
  `EBSD_ASSERT_HOLDS(a_div_count_range, state != S_DIV || cnt <= LAST_STEP)
  `EBSD_ASSERT_NEXT(a_div_ends, state == S_DIV && cnt == LAST_STEP, state == S_RATIO)

endmodule

FILE: hdl/encoder_balanced_straight_drive.sv
// ----------------------------------------------------------------------------
// encoder_balanced_straight_drive
// two wheel straight drive balanced on encoder counts, one result per item
// ----------------------------------------------------------------------------
// sequence: a start, a sample while stopped, a sample at the target or with level
//   counts go from classify straight to commit; a lagging wheel also passes the
//   40 step restoring divider, the ratio clamp and 2 multiplies before the commit
// throughput: one item at a time, next taken the cycle after the result is
//   parked; a held result blocks the commit and so the next item
// reset (rst, synchronous): stopped, duties 0, forward, registers at defaults
// ----------------------------------------------------------------------------
module encoder_balanced_straight_drive (
  input  logic                                clk,
  input  logic                                rst,
  // item in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // left_count [23:0], right_count [47:24]
  input  logic [ebsd_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // mode: 0 start a move, 1 encoder sample
  input  logic                                s_tuser,
  // result out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // motor_enable [0], left_pwm [16:1], right_pwm [32:17], dir_left [33],
  // dir_right [34], move_done [35], zero fill [39:36]
  output logic [ebsd_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // register writes: 0 target_counts, 1 forward, 2 slow_duty,
  // 3 left wheel trim gain
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ebsd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [ebsd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ebsd_pkg::*;

  ebsd_cfg_t cfg;
  ebsd_cmd_t cmd;
  ebsd_sts_t sts;

  // register file; user writes between items to hit the next item, not enforced
  ebsd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle, classify, then either straight to commit or through the
  // divider, the ratio clamp and both multiplier stages
  ebsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds the drive state, the divider and the result register
  ebsd_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg      (cfg),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: dv/encoder_balanced_straight_drive_tb.sv
// ----------------------------------------------------------------------------
// encoder_balanced_straight_drive_tb
// self-checking bench for the straight drive: a queue-fed driver sends start
// and encoder sample items, an in-bench drive model predicts each result and
// a monitor compares every result field against the oldest prediction
// ----------------------------------------------------------------------------
module encoder_balanced_straight_drive_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebsd_pkg::*;

  localparam longint RATIO_TOP    = 64'sd16777215;    // 2^24 - 1
  localparam longint RATIO_BOTTOM = -64'sd16777216;   // -2^24
  localparam longint COUNT_TOP    = 64'sd8388607;
  localparam longint COUNT_BOTTOM = -64'sd8388608;

  // one input item: mode travels on tuser, both counts on tdata
  typedef struct {
    logic                  mode;
    logic [COUNT_BITS-1:0] left;
    logic [COUNT_BITS-1:0] right;
  } wheel_item_t;

  // one result item as unpacked from m_tdata
  typedef struct {
    logic                 enable;
    logic [DUTY_BITS-1:0] left_pwm;
    logic [DUTY_BITS-1:0] right_pwm;
    logic                 dir_left;
    logic                 dir_right;
    logic                 done;
  } drive_out_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // register copies kept by the drive model
  logic [TARGET_BITS-1:0] sh_target = '0;
  logic                   sh_fwd = 1'b1;
  logic [DUTY_BITS-1:0]   sh_slow = 16'd19661;
  logic [CF_BITS-1:0]     sh_corr = 16'd4096;

  // drive model state
  logic                 mdl_moving = 1'b0;
  logic                 mdl_dir = 1'b1;
  logic [DUTY_BITS-1:0] mdl_lduty = '0;
  logic [DUTY_BITS-1:0] mdl_rduty = '0;

  wheel_item_t pending_items[$];
  wheel_item_t drv_item;
  drive_out_t  expected_q[$];
  drive_out_t  got_res;
  drive_out_t  want_res;

  int unsigned pushed = 0;
  int unsigned accepted = 0;
  int unsigned mismatches = 0;
  int unsigned gap_pct = 0;      // sender idle chance per cycle
  int unsigned stall_pct = 0;    // receiver stall chance per cycle
  int unsigned hold_cycles = 0;
  int unsigned hold_cnt = 0;
  bit          hold_tgl = 1'b0;
  bit          hold_seen = 1'b0;
  bit          in_hs = 1'b0;
  bit          cfg_hs = 1'b0;

  encoder_balanced_straight_drive i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // drive model
  // --------------------------------------------------------------------------

  function automatic logic [63:0] mag64(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // signed Q8.16 quotient num / den, saturated, zero divisor by numerator sign
  function automatic longint ratio_q16(longint num, longint den);
    bit          neg;
    logic [63:0] q;
    if (num == 0) return 0;
    if (den == 0) return (num > 0) ? RATIO_TOP : RATIO_BOTTOM;
    neg = (num < 0) != (den < 0);
    q = (mag64(num) << RATIO_FRAC) / mag64(den);
    if (neg) return (q >= 64'd16777216) ? RATIO_BOTTOM : -longint'(q);
    return (q >= 64'(RATIO_TOP)) ? RATIO_TOP : longint'(q);
  endfunction

  function automatic logic [DUTY_BITS-1:0] sat_duty(logic [63:0] d);
    return (d > 64'hFFFF) ? 16'hFFFF : d[DUTY_BITS-1:0];
  endfunction

  // slow duty times ratio, nothing for a negative or zero ratio
  function automatic logic [63:0] scale_slow(longint rv);
    if (rv <= 0) return 64'd0;
    return (64'(sh_slow) * 64'(rv)) >> RATIO_FRAC;
  endfunction

  function automatic logic [DUTY_BITS-1:0] gain_left(logic [63:0] d);
    return sat_duty((d * 64'(sh_corr)) >> CF_FRAC);
  endfunction

  function automatic drive_out_t drive_step(logic mode, logic [IN_DATA_BITS-1:0] cnts);
    longint     l;
    longint     r;
    drive_out_t res;
    l = $signed({{40{cnts[COUNT_BITS-1]}}, cnts[COUNT_BITS-1:0]});
    r = $signed({{40{cnts[IN_DATA_BITS-1]}}, cnts[IN_DATA_BITS-1:COUNT_BITS]});
    res.enable = 1'b0;
    res.done = 1'b0;
    if (mode == MODE_START) begin
      mdl_dir = sh_fwd;
      mdl_lduty = sh_slow;
      mdl_rduty = sh_slow;
      mdl_moving = 1'b1;
    end else if (mdl_moving) begin
      if (mag64(l + r) >= (64'(sh_target) << 1)) begin
        mdl_moving = 1'b0;
        res.done = 1'b1;
      end else begin
        res.enable = 1'b1;
        if ((mdl_dir && l < r) || (!mdl_dir && l > r)) begin
          mdl_lduty = gain_left(scale_slow(ratio_q16(r, l + 1)));
          mdl_rduty = sh_slow;
        end else if ((mdl_dir && r < l) || (!mdl_dir && r > l)) begin
          mdl_rduty = sat_duty(scale_slow(ratio_q16(l, r + 1)));
          mdl_lduty = gain_left(sh_slow);
        end
      end
    end
    res.left_pwm = ~mdl_lduty;
    res.right_pwm = ~mdl_rduty;
    res.dir_left = mdl_dir;
    res.dir_right = mdl_dir;
    return res;
  endfunction

  function automatic void check_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver, receiver and monitor
  // --------------------------------------------------------------------------

  // item driver: a new item goes out once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_hs) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        drv_item = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= drv_item.mode;
        s_tdata  <= {drv_item.right, drv_item.left};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // hold-off counter, restarted each time the request flag toggles
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_cnt  <= hold_cycles;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: predict on every accepted item, check on every accepted result
  always @(posedge clk) begin
    in_hs  <= s_tvalid && s_tready && !rst;
    cfg_hs <= cfg_valid && cfg_ready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      accepted++;
      expected_q.push_back(drive_step(s_tuser, s_tdata));
    end
    if (!rst && m_tvalid && m_tready) begin
      got_res.enable    = m_tdata[0];
      got_res.left_pwm  = m_tdata[16:1];
      got_res.right_pwm = m_tdata[32:17];
      got_res.dir_left  = m_tdata[33];
      got_res.dir_right = m_tdata[34];
      got_res.done      = m_tdata[35];
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, m_tdata);
        mismatches++;
      end else begin
        want_res = expected_q.pop_front();
        check_field("motor_enable", want_res.enable, got_res.enable);
        check_field("left_pwm", want_res.left_pwm, got_res.left_pwm);
        check_field("right_pwm", want_res.right_pwm, got_res.right_pwm);
        check_field("dir_left", want_res.dir_left, got_res.dir_left);
        check_field("dir_right", want_res.dir_right, got_res.dir_right);
        check_field("move_done", want_res.done, got_res.done);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  task automatic push_item(logic mode, longint l, longint r);
    wheel_item_t it;
    it.mode  = mode;
    it.left  = l[COUNT_BITS-1:0];
    it.right = r[COUNT_BITS-1:0];
    pending_items.push_back(it);
    pushed++;
  endtask

  // block idle: every item taken and every result back
  task automatic drain();
    while (accepted != pushed || expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_hs);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TARGET:  sh_target = val;
      REG_FORWARD: sh_fwd = val[0];
      REG_SLOW:    sh_slow = val[DUTY_BITS-1:0];
      REG_CORR:    sh_corr = val[CF_BITS-1:0];
      default: ;
    endcase
  endtask

  function automatic longint clamp_count(longint v);
    if (v > COUNT_TOP) return COUNT_TOP;
    if (v < COUNT_BOTTOM) return COUNT_BOTTOM;
    return v;
  endfunction

  // one move: a start, then samples closing in on the target and a few past it
  task automatic queue_move();
    longint      lc;
    longint      rc;
    longint      sgn;
    int unsigned stepv;
    int          n;
    n = $urandom_range(3, 16);
    sgn = sh_fwd ? 1 : -1;
    stepv = 32'((2 * longint'(sh_target)) / n + 1);
    lc = 0;
    rc = 0;
    push_item(MODE_START, longint'($urandom_range(0, 16777215)),
              longint'($urandom_range(0, 16777215)));
    repeat (n + 2) begin
      case ($urandom_range(0, 11))
        0: rc = lc;                                        // wheels level
        1: lc = clamp_count(lc + sgn * longint'($urandom_range(0, stepv)));
        2: rc = clamp_count(rc + sgn * longint'($urandom_range(0, stepv)));
        3: lc = -1;                                        // zero divisor
        4: rc = -1;
        default: begin
          lc = clamp_count(lc + sgn * longint'($urandom_range(0, stepv)));
          rc = clamp_count(rc + sgn * longint'($urandom_range(0, stepv)));
        end
      endcase
      push_item(MODE_SAMPLE, lc, rc);
    end
  endtask

  task automatic queue_noise();
    push_item(1'($urandom_range(0, 1)), longint'($urandom_range(0, 16777215)),
              longint'($urandom_range(0, 16777215)));
  endtask

  initial begin
    int unsigned base;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, forward first
    reg_write(REG_TARGET, 23'd100);
    reg_write(REG_FORWARD, 23'd1);
    reg_write(REG_SLOW, 23'h8000);
    reg_write(REG_CORR, 23'd4096);
    push_item(MODE_SAMPLE, 0, 0);          // sample while stopped
    push_item(MODE_START, 0, 0);
    push_item(MODE_SAMPLE, 10, 10);        // level wheels hold the duties
    push_item(MODE_SAMPLE, 5, 20);         // left behind
    push_item(MODE_SAMPLE, 30, 10);        // right behind
    push_item(MODE_SAMPLE, -1, 40);        // zero divisor, positive numerator
    push_item(MODE_SAMPLE, -1, 0);         // zero divisor, zero numerator
    push_item(MODE_SAMPLE, -5, 3);         // negative ratio
    push_item(MODE_SAMPLE, -20, -5);       // both negative, positive ratio
    push_item(MODE_SAMPLE, 30, -1);        // right zero divisor
    push_item(MODE_SAMPLE, 100, 100);      // target reached exactly
    push_item(MODE_SAMPLE, 3, 50);         // sample after the move ended
    push_item(MODE_START, 0, 0);
    push_item(MODE_START, 0, 0);           // restart while moving
    drain();

    // reverse with extreme duty and gain, direction latched at the next start
    reg_write(REG_FORWARD, 23'd0);
    reg_write(REG_SLOW, 23'hFFFF);
    reg_write(REG_CORR, 23'hFFFF);
    push_item(MODE_SAMPLE, 40, 2);         // still running forward
    push_item(MODE_START, 0, 0);
    push_item(MODE_SAMPLE, -10, -30);
    push_item(MODE_SAMPLE, -40, -5);
    push_item(MODE_SAMPLE, COUNT_TOP, COUNT_BOTTOM);
    push_item(MODE_SAMPLE, COUNT_BOTTOM, COUNT_TOP);
    push_item(MODE_SAMPLE, COUNT_BOTTOM, COUNT_BOTTOM);
    drain();

    // zero target ends a move on its first sample
    reg_write(REG_TARGET, 23'd0);
    push_item(MODE_START, 0, 0);
    push_item(MODE_SAMPLE, 0, 0);
    drain();

    // random phases, each with its own settings and idling pattern
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 59; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      if (ph == 1)
        reg_write(REG_TARGET, 23'd0);
      else if (ph == 5)
        reg_write(REG_TARGET, 23'h7FFFFF);
      else
        reg_write(REG_TARGET,
                  CFG_DATA_BITS'($urandom_range(1, (ph % 3 == 0) ? 500 : 40000)));
      reg_write(REG_FORWARD, CFG_DATA_BITS'(ph % 2));
      if (ph == 2)
        reg_write(REG_SLOW, 23'd0);
      else if (ph == 3)
        reg_write(REG_SLOW, 23'hFFFF);
      else
        reg_write(REG_SLOW, CFG_DATA_BITS'($urandom_range(0, 65535)));
      if (ph == 4)
        reg_write(REG_CORR, 23'd0);
      else if (ph == 6)
        reg_write(REG_CORR, 23'hFFFF);
      else
        reg_write(REG_CORR, CFG_DATA_BITS'($urandom_range(2048, 8192)));
      base = pushed;
      while (pushed - base < 105) begin
        if ($urandom_range(0, 5) == 0) queue_noise();
        else queue_move();
      end
      drain();
    end

    // back-pressure: receiver holds off long enough for the input to stall
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles = 400;
    hold_tgl = ~hold_tgl;
    base = pushed;
    while (pushed - base < 40) queue_move();
    drain();

    repeat (60) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("encoder_balanced_straight_drive_tb passed");
    end else begin
      $display("encoder_balanced_straight_drive_tb failed");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #8000000;
    $display("encoder_balanced_straight_drive_tb failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/ebsd_pkg.sv
hdl/ebsd_regs.sv
hdl/ebsd_dpath.sv
hdl/ebsd_ctrl.sv
hdl/encoder_balanced_straight_drive.sv
dv/encoder_balanced_straight_drive_tb.sv
